// File: sv/angle_pid_with_clamps_core_assert.svh
// Assertion macros for the angle PID core.
// Needs nothing else; include with the bare file name inside a module body.
`ifndef ANGLE_PID_WITH_CLAMPS_CORE_ASSERT_SVH
`define ANGLE_PID_WITH_CLAMPS_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define APID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define APID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/apid_pkg.sv
// Shared types and constants of the angle PID core.
// No dependencies; imported by the channel interfaces and every module.
`default_nettype none

package apid_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int INTEG_W    = 25;
    localparam int ERR_SUM_W  = DATA_WIDTH + 2;
    localparam int DIFF_W     = DATA_WIDTH + 1;
    localparam int P_W        = GAIN_W + 1 + DATA_WIDTH;
    localparam int D_W        = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W      = D_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [DATA_WIDTH-1:0] RST_ANGLE_OFFSET   = -16'sd486;
    localparam logic [GAIN_W-1:0]            RST_GAIN_P         = 16'd384;
    localparam logic [GAIN_W-1:0]            RST_GAIN_I         = 16'd90;
    localparam logic [GAIN_W-1:0]            RST_GAIN_D         = 16'd845;
    localparam logic [LIMIT_W-1:0]           RST_INTEGRAL_LIMIT = 15'd10240;
    localparam logic [LIMIT_W-1:0]           RST_OUTPUT_LIMIT   = 15'd21760;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_OFFSET   = 3'd0,
        CFG_GAIN_P         = 3'd1,
        CFG_GAIN_I         = 3'd2,
        CFG_GAIN_D         = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_OUTPUT_LIMIT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] angle_offset;
        logic [GAIN_W-1:0]            gain_p;
        logic [GAIN_W-1:0]            gain_i;
        logic [GAIN_W-1:0]            gain_d;
        logic [LIMIT_W-1:0]           integral_limit;
        logic [LIMIT_W-1:0]           output_limit;
    } t_cfg;

    // Per-sample terms produced by the control law.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] err;
        logic signed [P_W-1:0]        p_term;
        logic signed [D_W-1:0]        d_term;
        logic signed [INTEG_W-1:0]    integ;
    } t_terms;

endpackage

`default_nettype wire

// File: sv/apid_if.sv
// Valid/ready channel interfaces for the angle PID core.
// Depends on apid_pkg for field widths.
`default_nettype none

interface apid_req_if;
    import apid_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] measured_angle;
    logic signed [DATA_WIDTH-1:0] target_angle;
    modport source (output valid, output measured_angle, output target_angle, input ready);
    modport sink   (input valid, input measured_angle, input target_angle, output ready);
endinterface

interface apid_rsp_if;
    import apid_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive_value;
    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

// File: sv/apid_law.sv
// Control law of the angle PID core: error, P and D products, clamped integral.
// Depends on apid_pkg.
`default_nettype none

module apid_law (
    input  logic signed [apid_pkg::DATA_WIDTH-1:0] i_measured_angle,
    input  logic signed [apid_pkg::DATA_WIDTH-1:0] i_target_angle,
    input  apid_pkg::t_cfg                         i_cfg,
    input  logic signed [apid_pkg::INTEG_W-1:0]    i_integ,
    input  logic signed [apid_pkg::DATA_WIDTH-1:0] i_prev_err,
    output apid_pkg::t_terms                       o_terms
);
    import apid_pkg::*;

    localparam logic signed [ERR_SUM_W-1:0] ERR_MAX =
        ERR_SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ERR_SUM_W-1:0] ERR_MIN = -ERR_MAX - ERR_SUM_W'(1);

    logic signed [ERR_SUM_W-1:0] err_sum;
    logic signed [DATA_WIDTH-1:0] err;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [P_W-1:0]       i_prod;
    logic signed [ACC_W-1:0]     integ_sum;
    logic signed [ACC_W-1:0]     integ_lim;

    // Saturate the raw error to the data width.
    always_comb begin
        err_sum = ERR_SUM_W'(i_measured_angle) - ERR_SUM_W'(i_target_angle)
                + ERR_SUM_W'(i_cfg.angle_offset);
        if (err_sum > ERR_MAX) begin
            err = ERR_MAX[DATA_WIDTH-1:0];
        end else if (err_sum < ERR_MIN) begin
            err = ERR_MIN[DATA_WIDTH-1:0];
        end else begin
            err = err_sum[DATA_WIDTH-1:0];
        end
    end

    assign diff   = DIFF_W'(err) - DIFF_W'(i_prev_err);
    assign i_prod = $signed({1'b0, i_cfg.gain_i}) * err;

    // Accumulate and clamp the integral symmetrically.
    always_comb begin
        integ_sum = ACC_W'(i_integ) + ACC_W'(i_prod);
        integ_lim = $signed({{(ACC_W - LIMIT_W - FRAC_BITS){1'b0}},
                             i_cfg.integral_limit, {FRAC_BITS{1'b0}}});
        o_terms.err    = err;
        o_terms.p_term = $signed({1'b0, i_cfg.gain_p}) * err;
        o_terms.d_term = $signed({1'b0, i_cfg.gain_d}) * diff;
        if (integ_sum > integ_lim) begin
            o_terms.integ = integ_lim[INTEG_W-1:0];
        end else if (integ_sum < -integ_lim) begin
            o_terms.integ = INTEG_W'(-integ_lim);
        end else begin
            o_terms.integ = integ_sum[INTEG_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/angle_pid_with_clamps_core.sv
// Angle PID core: one positional PID step per request, one drive value per request.
// Depends on apid_pkg, apid_if.sv, apid_law and the assertion macro header.
//
// Each request carries a measured and a target tilt angle (signed Q7.8). The
// error is measured - target + angle_offset, saturated to 16 bits. The drive
// value is P + I + D, clamped to +/- output_limit and floored back to Q7.8; the
// integral adds gain_i * error each request and is held within
// +/- integral_limit. The integral and the previous error start at zero after
// reset. A request passes three registers (input register, term register,
// output register): it is loaded into the input register at its acceptance
// edge and then passes the term and output registers as the pipe advances. One
// request is taken every cycle while the output side keeps up; the integral and
// previous-error feedback close within the single term stage. Write the
// configuration only while no request is in flight.
`default_nettype none

module angle_pid_with_clamps_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [apid_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    apid_req_if.sink                            i_req,
    apid_rsp_if.source                          o_rsp
);
    import apid_pkg::*;

    `include "angle_pid_with_clamps_core_assert.svh"

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_offset   <= RST_ANGLE_OFFSET;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.integral_limit <= RST_INTEGRAL_LIMIT;
            r_cfg.output_limit   <= RST_OUTPUT_LIMIT;
        end else if (i_cfg_we) begin
            // Keep only the low bits of each register; drop unknown indexes.
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ANGLE_OFFSET:   r_cfg.angle_offset   <= $signed(i_cfg_wdata[DATA_WIDTH-1:0]);
                CFG_GAIN_P:         r_cfg.gain_p         <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:         r_cfg.gain_i         <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:         r_cfg.gain_d         <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: the whole pipe advances together whenever the output
    // register is empty or being drained this cycle. Bubbles travel as
    // cleared valid bits.
    // ---------------------------------------------------------------------
    logic adv;
    logic r_a_valid, r_b_valid, r_c_valid;

    assign adv         = !r_c_valid || o_rsp.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_req.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // ---------------------------------------------------------------------
    // Stage A: input register
    // ---------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] r_meas, r_tgt;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_meas <= i_req.measured_angle;
            r_tgt  <= i_req.target_angle;
        end
    end

    // ---------------------------------------------------------------------
    // Stage B: terms and controller state. The integral register is both the
    // stored state and the integral term of the request now in stage B.
    // ---------------------------------------------------------------------
    t_terms terms;
    logic signed [P_W-1:0]        r_p;
    logic signed [D_W-1:0]        r_d;
    logic signed [INTEG_W-1:0]    r_integ, n_integ;
    logic signed [DATA_WIDTH-1:0] r_prev_err, n_prev_err;
    logic                         upd;

    apid_law u_law (
        .i_measured_angle (r_meas),
        .i_target_angle   (r_tgt),
        .i_cfg            (r_cfg),
        .i_integ          (r_integ),
        .i_prev_err       (r_prev_err),
        .o_terms          (terms)
    );

    assign upd = adv && r_a_valid;

    // Advance the state only for a real request; hold it across bubbles.
    always_comb begin
        n_integ    = r_integ;
        n_prev_err = r_prev_err;
        if (upd) begin
            n_integ    = terms.integ;
            n_prev_err = terms.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_prev_err <= '0;
        end else begin
            r_integ    <= n_integ;
            r_prev_err <= n_prev_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_p <= terms.p_term;
            r_d <= terms.d_term;
        end
    end

    // ---------------------------------------------------------------------
    // Stage C: sum, output clamp, floor shift back to Q7.8
    // ---------------------------------------------------------------------
    logic signed [ACC_W-1:0]      pid_sum, out_lim, pid_clamped;
    logic signed [DATA_WIDTH-1:0] r_drive;

    always_comb begin
        pid_sum = ACC_W'(r_p) + ACC_W'(r_integ) + ACC_W'(r_d);
        out_lim = $signed({{(ACC_W - LIMIT_W - FRAC_BITS){1'b0}},
                           r_cfg.output_limit, {FRAC_BITS{1'b0}}});
        if (pid_sum > out_lim) begin
            pid_clamped = out_lim;
        end else if (pid_sum < -out_lim) begin
            pid_clamped = -out_lim;
        end else begin
            pid_clamped = pid_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid) begin
            // Arithmetic shift right floors toward minus infinity.
            r_drive <= pid_clamped[DATA_WIDTH+FRAC_BITS-1:FRAC_BITS];
        end
    end

    assign o_rsp.valid       = r_c_valid;
    assign o_rsp.drive_value = r_drive;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `APID_ASSERT_NOW(a_drive_in_limit, i_clk, i_rst_n, o_rsp.valid,
        ($signed({1'b0, r_cfg.output_limit}) >= 17'(r_drive)) &&
        (-$signed({1'b0, r_cfg.output_limit}) <= 17'(r_drive)),
        "drive value outside the output limit")
    `APID_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !(adv && r_a_valid),
        $stable(r_integ) && $stable(r_prev_err),
        "PID state changed without a request")
    `APID_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_c_valid,
        i_req.ready, "request refused with empty output register")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for angle_pid_with_clamps_core: a directed table and then random requests.
// Depends on apid_pkg and the channel interfaces in apid_if.sv; the core is the only other unit.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apid_pkg::*;

    // Register slots beyond the last real register; the core must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam int N_CHUNKS   = 16;  // random chunks, each under its own register settings
    localparam int CHUNK_REQS = 96;  // requests per random chunk
    localparam int MAX_PRINT  = 40;  // mismatch lines printed before going quiet

    // One row of the directed table: either a register write or a request.
    typedef struct {
        bit                           is_cfg;
        logic [CFG_IDX_W-1:0]         idx;
        logic [CFG_DATA_W-1:0]        data;
        logic signed [DATA_WIDTH-1:0] meas;
        logic signed [DATA_WIDTH-1:0] tgt;
        bit                           typed;  // drive value given in the row itself
        logic signed [DATA_WIDTH-1:0] drive;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    apid_req_if req_ch ();
    apid_rsp_if rsp_ch ();

    angle_pid_with_clamps_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Control-law mirror: register copy, integral and previous error
    // ------------------------------------------------------------------
    t_cfg   law_cfg;
    longint integ_acc;   // integral, 2*FRAC_BITS fraction bits
    longint last_err;    // previous saturated error, Q7.8

    // Drive values still owed by the core, oldest first.
    logic signed [DATA_WIDTH-1:0] pending_drive [$];

    int mismatches     = 0;
    int requests_sent  = 0;
    int directed_reqs  = 0;
    int drives_checked = 0;
    int reg_writes     = 0;

    // Idling knobs, read by the request driver and by the response taker.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    function automatic longint clamp_mag(input longint v, input longint mag);
        if (v > mag) return mag;
        if (v < -mag) return -mag;
        return v;
    endfunction

    // Advance the mirror by one sample and return the drive value it implies.
    function automatic logic signed [DATA_WIDTH-1:0] next_drive(
        input logic signed [DATA_WIDTH-1:0] meas,
        input logic signed [DATA_WIDTH-1:0] tgt
    );
        longint emax, err, p, d, sum;
        emax = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        err  = longint'(meas) - longint'(tgt) + longint'($signed(law_cfg.angle_offset));
        if (err > emax) err = emax;
        if (err < -emax - 1) err = -emax - 1;

        p = longint'(law_cfg.gain_p) * err;

        // Accumulate first, then clamp to the integral limit.
        integ_acc = clamp_mag(integ_acc + longint'(law_cfg.gain_i) * err,
                              longint'(law_cfg.integral_limit) <<< FRAC_BITS);

        d        = longint'(law_cfg.gain_d) * (err - last_err);
        last_err = err;

        sum = clamp_mag(p + integ_acc + d, longint'(law_cfg.output_limit) <<< FRAC_BITS);
        // Arithmetic shift floors negative sums towards minus infinity.
        return DATA_WIDTH'(sum >>> FRAC_BITS);
    endfunction

    // Mirror a register write; spare indexes and excess bits drop out here.
    function automatic void take_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ANGLE_OFFSET:   law_cfg.angle_offset   = data;
            CFG_GAIN_P:         law_cfg.gain_p         = data;
            CFG_GAIN_I:         law_cfg.gain_i         = data;
            CFG_GAIN_D:         law_cfg.gain_d         = data;
            CFG_INTEGRAL_LIMIT: law_cfg.integral_limit = data[LIMIT_W-1:0];
            CFG_OUTPUT_LIMIT:   law_cfg.output_limit   = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINT) $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // Offer one request and hold it until the core takes it. Called in the
    // step of the previous acceptance, so valid gets exactly one update here.
    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] meas,
                               input logic signed [DATA_WIDTH-1:0] tgt,
                               input bit                           typed,
                               input logic signed [DATA_WIDTH-1:0] typed_drive);
        logic signed [DATA_WIDTH-1:0] drive;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.measured_angle <= meas;
        req_ch.target_angle   <= tgt;
        do @(posedge i_clk); while (!req_ch.ready);
        // Accepted at this edge: advance the mirror even for typed rows.
        drive = next_drive(meas, tgt);
        pending_drive.push_back(typed ? typed_drive : drive);
        requests_sent++;
    endtask

    // Drop valid and let every owed drive value come home.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
    endtask

    // One write pulse on an idle core, followed by a wait with write enable low.
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        take_reg(idx, data);
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0]  idx,
                                     input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_row req_row(input logic signed [DATA_WIDTH-1:0] meas,
                                     input logic signed [DATA_WIDTH-1:0] tgt,
                                     input bit                           typed,
                                     input logic signed [DATA_WIDTH-1:0] drive);
        t_row r;
        r       = '{default: '0};
        r.meas  = meas;
        r.tgt   = tgt;
        r.typed = typed;
        r.drive = drive;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response taker: checks drive values and plays the stalling receiver
    // ------------------------------------------------------------------
    initial begin
        logic signed [DATA_WIDTH-1:0] want;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (pending_drive.size() == 0) begin
                    report_mismatch($sformatf("drive_value %0d with no request owed",
                                              rsp_ch.drive_value));
                end else begin
                    want = pending_drive.pop_front();
                    if (rsp_ch.drive_value !== want)
                        report_mismatch($sformatf("drive_value got %0d want %0d (result %0d)",
                                                  rsp_ch.drive_value, want, drives_checked));
                    drives_checked++;
                end
            end
            // A long hold-off backs the core up until it refuses requests.
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Hard stop in case the core hangs on a handshake.
    initial begin
        #400_000;
        $display("timeout with %0d drive values still owed", pending_drive.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row                          plan [$];
        logic [CFG_DATA_W-1:0]         off, kp, ki, kd, il, ol;
        logic signed [DATA_WIDTH-1:0]  meas, tgt;
        int                            a, b;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= CFG_ANGLE_OFFSET;
        i_cfg_wdata           <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.measured_angle <= '0;
        req_ch.target_angle   <= '0;

        law_cfg.angle_offset   = RST_ANGLE_OFFSET;
        law_cfg.gain_p         = RST_GAIN_P;
        law_cfg.gain_i         = RST_GAIN_I;
        law_cfg.gain_d         = RST_GAIN_D;
        law_cfg.integral_limit = RST_INTEGRAL_LIMIT;
        law_cfg.output_limit   = RST_OUTPUT_LIMIT;
        integ_acc              = 0;
        last_err               = 0;

        // Directed table. Typed drive values follow straight from the row:
        // zero error after reset, full clamps, zero limits and floor rounding.
        // Measured equal to minus the reset offset gives zero error and no output.
        plan.push_back(req_row(16'sd486, 16'sd0, 1'b1, 16'sd0));
        // Error saturating high, then low: the low ones pin the output clamp.
        plan.push_back(req_row(16'sh7FFF, 16'sh8000, 1'b0, '0));
        plan.push_back(req_row(16'sh8000, 16'sh7FFF, 1'b1, -16'sd21760));
        plan.push_back(req_row(16'sh8000, 16'sh7FFF, 1'b1, -16'sd21760));
        // A zero output limit forces the drive to zero.
        plan.push_back(cfg_row(CFG_OUTPUT_LIMIT, 16'h0000));
        plan.push_back(req_row(16'sd12345, -16'sd2222, 1'b1, 16'sd0));
        // Bit 15 of a limit write falls away: this lands as the largest limit.
        plan.push_back(cfg_row(CFG_OUTPUT_LIMIT, 16'hFFFF));
        plan.push_back(req_row(16'sd1000, -16'sd300, 1'b0, '0));
        // No gains and a zero integral limit: the integral is flushed, drive is zero.
        plan.push_back(cfg_row(CFG_GAIN_P, 16'h0000));
        plan.push_back(cfg_row(CFG_GAIN_I, 16'h0000));
        plan.push_back(cfg_row(CFG_GAIN_D, 16'h0000));
        plan.push_back(cfg_row(CFG_INTEGRAL_LIMIT, 16'h0000));
        plan.push_back(req_row(16'sd20000, 16'sd5, 1'b1, 16'sd0));
        // Unit gain, P only: the drive is the error floored to whole units.
        plan.push_back(cfg_row(CFG_ANGLE_OFFSET, 16'h0000));
        plan.push_back(cfg_row(CFG_GAIN_P, 16'h0001));
        plan.push_back(req_row(-16'sd1,   16'sd0, 1'b1, -16'sd1));
        plan.push_back(req_row(16'sd1,    16'sd0, 1'b1, 16'sd0));
        plan.push_back(req_row(-16'sd255, 16'sd0, 1'b1, -16'sd1));
        plan.push_back(req_row(-16'sd257, 16'sd0, 1'b1, -16'sd2));
        plan.push_back(req_row(16'sh7FFF, 16'sh8000, 1'b1, 16'sd127));
        plan.push_back(req_row(16'sh8000, 16'sh7FFF, 1'b1, -16'sd128));
        // Writes to spare slots must leave the unit gain alone.
        plan.push_back(cfg_row(IDX_SPARE_LO, 16'hFFFF));
        plan.push_back(cfg_row(IDX_SPARE_HI, 16'h8000));
        plan.push_back(req_row(-16'sd256, 16'sd0, 1'b1, -16'sd1));
        // Everything at the top, then the most negative offset.
        plan.push_back(cfg_row(CFG_GAIN_P, 16'hFFFF));
        plan.push_back(cfg_row(CFG_GAIN_I, 16'hFFFF));
        plan.push_back(cfg_row(CFG_GAIN_D, 16'hFFFF));
        plan.push_back(cfg_row(CFG_INTEGRAL_LIMIT, 16'hFFFF));
        plan.push_back(cfg_row(CFG_ANGLE_OFFSET, 16'h7FFF));
        plan.push_back(req_row(16'sh7FFF, 16'sh8000, 1'b0, '0));
        plan.push_back(req_row(16'sh8000, 16'sh7FFF, 1'b0, '0));
        plan.push_back(req_row(16'sd0,    16'sd0,    1'b0, '0));
        plan.push_back(cfg_row(CFG_ANGLE_OFFSET, 16'h8000));
        plan.push_back(req_row(16'sd0,    16'sd0,    1'b0, '0));
        plan.push_back(req_row(16'sh8000, 16'sh7FFF, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_sample(plan[i].meas, plan[i].tgt, plan[i].typed, plan[i].drive);
                directed_reqs++;
            end
        end

        // Random chunks: fresh register settings per chunk, idling cycled
        // through the four patterns so gaps land on every pipeline phase.
        for (int chunk = 0; chunk < N_CHUNKS; chunk++) begin
            case (chunk)
                0: begin  // everything at its largest
                    off = 16'h7FFF; kp = 16'hFFFF; ki = 16'hFFFF; kd = 16'hFFFF;
                    il  = 16'h7FFF; ol = 16'h7FFF;
                end
                1: begin  // integral shut off, output wide open
                    off = 16'h8000; kp = 16'hFFFF; ki = 16'hFFFF; kd = 16'h0000;
                    il  = 16'h0000; ol = 16'hFFFF;
                end
                2: begin  // output clamped to one unit either way
                    off = 16'h0000; kp = 16'h0100; ki = 16'h0040; kd = 16'h0080;
                    il  = 16'hFFFF; ol = 16'h0001;
                end
                default: begin
                    off = ($urandom_range(1) != 0) ? 16'($urandom)
                                                   : 16'(int'($urandom_range(2047)) - 1024);
                    kp  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1023));
                    ki  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(255));
                    kd  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1023));
                    il  = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
                    ol  = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
                end
            endcase
            write_reg(CFG_ANGLE_OFFSET,   off);
            write_reg(CFG_GAIN_P,         kp);
            write_reg(CFG_GAIN_I,         ki);
            write_reg(CFG_GAIN_D,         kd);
            write_reg(CFG_INTEGRAL_LIMIT, il);
            write_reg(CFG_OUTPUT_LIMIT,   ol);
            if ($urandom_range(3) == 0)
                write_reg(($urandom_range(1) != 0) ? IDX_SPARE_HI : IDX_SPARE_LO, 16'($urandom));

            case (chunk % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // Once, stop taking drive values for a long while and keep offering.
            if (chunk == 4) hold_cycles = 250;

            repeat (CHUNK_REQS) begin
                case ($urandom_range(9))
                    0, 1: begin  // anywhere in range, often saturating the error
                        a = $urandom;
                        b = $urandom;
                    end
                    2, 3, 4, 5, 6: begin  // tracking closely, terms mostly unclamped
                        b = int'($urandom_range(4095)) - 2048;
                        a = b + int'($urandom_range(1023)) - 512;
                    end
                    default: begin
                        a = int'($urandom_range(16383)) - 8192;
                        b = int'($urandom_range(16383)) - 8192;
                    end
                endcase
                meas = DATA_WIDTH'(a);
                tgt  = DATA_WIDTH'(b);
                send_sample(meas, tgt, 1'b0, '0);
            end
        end

        // Drain, then keep watching the response side so anything unowed can show up.
        settle_block();
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests (%0d from the directed table), %0d drive values checked",
                 requests_sent, directed_reqs, drives_checked);
        $display("%0d register writes over %0d settings, four idling patterns and one long hold-off",
                 reg_writes, N_CHUNKS + 1);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/apid_pkg.sv
sv/apid_if.sv
sv/apid_law.sv
sv/angle_pid_with_clamps_core.sv
tb/sv/tb.sv
